FILE: design/stk_pkg.sv
// Shared types, constants and keyword table for the source tokenizer.
package stk_pkg;

   localparam int OFFSET_BITS_DEF   = 16;
   localparam int KEYWORD_CHARS_DEF = 6;
   localparam int QUEUE_DEPTH       = 4;
   localparam int MAX_TOKENS        = 4;
   localparam int KEYWORD_COUNT     = 15;

   localparam logic [15:0] FIRST_LINE_RESET = 16'd1;
   localparam logic [15:0] LEN_MAX          = 16'hFFFF;
   localparam logic [62:0] VAL_MAX          = {63{1'b1}};

   localparam logic [5:0] K_END    = 6'd0;
   localparam logic [5:0] K_ERR    = 6'd1;
   localparam logic [5:0] K_IDENT  = 6'd2;
   localparam logic [5:0] K_KW0    = 6'd3;
   localparam logic [5:0] K_INT    = 6'd18;
   localparam logic [5:0] K_FLOAT  = 6'd19;
   localparam logic [5:0] K_LPAREN = 6'd20;
   localparam logic [5:0] K_RPAREN = 6'd21;
   localparam logic [5:0] K_LBRACE = 6'd22;
   localparam logic [5:0] K_RBRACE = 6'd23;
   localparam logic [5:0] K_SEMI   = 6'd24;
   localparam logic [5:0] K_COLON  = 6'd25;
   localparam logic [5:0] K_COMMA  = 6'd26;
   localparam logic [5:0] K_PERIOD = 6'd27;
   localparam logic [5:0] K_PLUS   = 6'd28;
   localparam logic [5:0] K_STAR   = 6'd29;
   localparam logic [5:0] K_SLASH  = 6'd30;
   localparam logic [5:0] K_AMP    = 6'd31;
   localparam logic [5:0] K_MINUS  = 6'd32;
   localparam logic [5:0] K_ARROW  = 6'd33;
   localparam logic [5:0] K_BANG   = 6'd34;
   localparam logic [5:0] K_NE     = 6'd35;
   localparam logic [5:0] K_ASSIGN = 6'd36;
   localparam logic [5:0] K_EQEQ   = 6'd37;
   localparam logic [5:0] K_LT     = 6'd38;
   localparam logic [5:0] K_LE     = 6'd39;
   localparam logic [5:0] K_GT     = 6'd40;
   localparam logic [5:0] K_GE     = 6'd41;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [62:0] value;
      logic        overflow;
      logic [7:0]  bad;
   } token_type;

   // All tokens completed by one item, slot 0 first.
   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tok;
      logic [2:0]                 count;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Keyword text packed big-endian into the low bytes.
   function automatic logic [63:0] kw_text(input logic [3:0] idx);
      logic [63:0] t;
      case (idx)
         4'd0:    t = 64'h6966;
         4'd1:    t = 64'h666E;
         4'd2:    t = 64'h666F72;
         4'd3:    t = 64'h693634;
         4'd4:    t = 64'h663634;
         4'd5:    t = 64'h693332;
         4'd6:    t = 64'h663332;
         4'd7:    t = 64'h656C7365;
         4'd8:    t = 64'h656E756D;
         4'd9:    t = 64'h626F6F6C;
         4'd10:   t = 64'h7768696C65;
         4'd11:   t = 64'h737472756374;
         4'd12:   t = 64'h65787465726E;
         4'd13:   t = 64'h676C6F62616C;
         4'd14:   t = 64'h72657475726E;
         default: t = 64'h0;
      endcase
      return t;
   endfunction

   function automatic logic [15:0] kw_len(input logic [3:0] idx);
      logic [15:0] l;
      case (idx)
         4'd0, 4'd1:                      l = 16'd2;
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6:    l = 16'd3;
         4'd7, 4'd8, 4'd9:                l = 16'd4;
         4'd10:                           l = 16'd5;
         4'd11, 4'd12, 4'd13, 4'd14:      l = 16'd6;
         default:                         l = 16'd0;
      endcase
      return l;
   endfunction

endpackage

FILE: design/stk_if.sv
// Handshake channels for source bytes in and tokens out.
interface stk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       byte_present;
   logic       source_end;
   modport source (output valid, source_byte, byte_present, source_end, input ready);
   modport sink (input valid, source_byte, byte_present, source_end, output ready);
endinterface

interface stk_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [15:0] token_offset;
   logic [15:0] token_length;
   logic [15:0] token_line;
   logic [62:0] integer_value;
   logic        value_overflow;
   logic [7:0]  bad_character;
   logic        last_of_run;
   modport source (output valid, token_kind, token_offset, token_length, token_line,
                   integer_value, value_overflow, bad_character, last_of_run,
                   input ready);
   modport sink (input valid, token_kind, token_offset, token_length, token_line,
                 integer_value, value_overflow, bad_character, last_of_run,
                 output ready);
endinterface

FILE: design/stk_front.sv
// Scanner: takes one byte per cycle while the bundle queue is not full and builds the bundle of tokens it completes.
module stk_front
   import stk_pkg::*;
#(
   parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   stk_req_if.sink          req,
   input  logic             cfg_we,
   input  logic [15:0]      cfg_data,
   input  queue_status_type qstat,
   output logic             push,
   output bundle_type       push_data
);

   localparam int PB = 8 * KEYWORD_CHARS;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_INTDOT, M_FRAC, M_COMMENT,
      M_SLASH, M_MINUS, M_BANG, M_EQ, M_LT, M_GT
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [OFFSET_BITS-1:0] start;
      logic [OFFSET_BITS-1:0] cur;
      logic [15:0]            line;
      logic [PB-1:0]          pre;
      logic [62:0]            acc;
      logic                   ovf;
      logic [15:0]            len;
   } st_type;

   st_type      st_ff, st_in;
   logic [15:0] first_line_ff;
   bundle_type  bnd;
   logic        accept;

   function automatic token_type mk(input logic [5:0] kind, input logic [15:0] off,
                                    input logic [15:0] len, input logic [15:0] line,
                                    input logic [62:0] val, input logic ovf,
                                    input logic [7:0] bad);
      token_type t;
      t.kind = kind; t.offset = off; t.length = len; t.line = line;
      t.value = val; t.overflow = ovf; t.bad = bad;
      return t;
   endfunction

   function automatic void emit(inout bundle_type b, input token_type t);
      b.tok[b.count[1:0]] = t;
      b.count = b.count + 3'd1;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == LEN_MAX) ? v : v + 16'd1;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] ident_kind(input st_type s);
      logic [5:0] k;
      k = K_IDENT;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (kw_len(4'(i)) == s.len && kw_text(4'(i)) == 64'(s.pre)) begin
            k = K_KW0 + 6'(i);
         end
      end
      return k;
   endfunction

   function automatic void flush(inout st_type s, inout bundle_type b);
      logic [15:0] so;
      so = 16'(s.start);
      case (s.mode)
         M_IDENT:  emit(b, mk(ident_kind(s), so, s.len, s.line, '0, 1'b0, '0));
         M_INT:    emit(b, mk(K_INT, so, s.len, s.line, s.acc, s.ovf, '0));
         M_INTDOT: begin
            emit(b, mk(K_INT, so, s.len, s.line, s.acc, s.ovf, '0));
            emit(b, mk(K_PERIOD, 16'(OFFSET_BITS'(s.cur - 1'b1)), 16'd1, s.line,
                       '0, 1'b0, '0));
         end
         M_FRAC:   emit(b, mk(K_FLOAT, so, s.len, s.line, '0, 1'b0, '0));
         M_SLASH:  emit(b, mk(K_SLASH, so, 16'd1, s.line, '0, 1'b0, '0));
         M_MINUS:  emit(b, mk(K_MINUS, so, 16'd1, s.line, '0, 1'b0, '0));
         M_BANG:   emit(b, mk(K_BANG, so, 16'd1, s.line, '0, 1'b0, '0));
         M_EQ:     emit(b, mk(K_ASSIGN, so, 16'd1, s.line, '0, 1'b0, '0));
         M_LT:     emit(b, mk(K_LT, so, 16'd1, s.line, '0, 1'b0, '0));
         M_GT:     emit(b, mk(K_GT, so, 16'd1, s.line, '0, 1'b0, '0));
         default:  ;
      endcase
      s.mode = M_IDLE;
   endfunction

   function automatic void idle_byte(inout st_type s, inout bundle_type b,
                                     input logic [7:0] c);
      logic [5:0] k;
      k = K_END;
      s.start = s.cur;
      s.len   = 16'd1;
      if (c == " " || c == 8'h09 || c == 8'h0D) begin
      end else if (c == 8'h0A) begin
         s.line = s.line + 16'd1;
      end else if (is_alpha(c)) begin
         s.mode = M_IDENT;
         s.pre  = PB'(c);
      end else if (is_digit(c)) begin
         s.mode = M_INT;
         s.acc  = 63'(c - "0");
         s.ovf  = 1'b0;
      end else begin
         case (c)
            "/":     s.mode = M_SLASH;
            "-":     s.mode = M_MINUS;
            "!":     s.mode = M_BANG;
            "=":     s.mode = M_EQ;
            "<":     s.mode = M_LT;
            ">":     s.mode = M_GT;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            ".":     k = K_PERIOD;
            "+":     k = K_PLUS;
            "*":     k = K_STAR;
            "&":     k = K_AMP;
            default: k = K_ERR;
         endcase
         if (k == K_ERR) begin
            emit(b, mk(K_ERR, 16'(s.start), 16'd1, s.line, '0, 1'b0, c));
         end else if (k != K_END) begin
            emit(b, mk(k, 16'(s.start), 16'd1, s.line, '0, 1'b0, '0));
         end
      end
   endfunction

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      st_type      s;
      bundle_type  b;
      logic [7:0]  c;
      logic        fl;
      logic [66:0] w;
      s  = st_ff;
      b  = '0;
      c  = req.source_byte;
      fl = 1'b0;
      // x*10 + d as shift-add; anything above bit 62 is overflow
      w  = (67'(st_ff.acc) << 3) + (67'(st_ff.acc) << 1) + 67'(c - "0");
      if (req.byte_present) begin
         case (s.mode)
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  if (s.len < 16'(KEYWORD_CHARS)) s.pre = PB'({s.pre, c});
                  s.len = sat_inc(s.len);
               end else fl = 1'b1;
            end
            M_INT: begin
               if (is_digit(c)) begin
                  if (s.ovf || w[66:63] != '0) begin
                     s.ovf = 1'b1;
                     s.acc = VAL_MAX;
                  end else s.acc = w[62:0];
                  s.len = sat_inc(s.len);
               end else if (c == ".") s.mode = M_INTDOT;
               else fl = 1'b1;
            end
            M_INTDOT: begin
               if (is_digit(c)) begin
                  s.mode = M_FRAC;
                  s.len  = sat_inc(sat_inc(s.len));
               end else fl = 1'b1;
            end
            M_FRAC: begin
               if (is_digit(c)) s.len = sat_inc(s.len);
               else fl = 1'b1;
            end
            M_COMMENT: begin
               if (c == 8'h0A) begin
                  s.line = s.line + 16'd1;
                  s.mode = M_IDLE;
               end
            end
            M_SLASH: begin
               if (c == "/") s.mode = M_COMMENT;
               else fl = 1'b1;
            end
            M_MINUS: begin
               if (c == ">") begin
                  emit(b, mk(K_ARROW, 16'(s.start), 16'd2, s.line, '0, 1'b0, '0));
                  s.mode = M_IDLE;
               end else fl = 1'b1;
            end
            M_BANG, M_EQ, M_LT, M_GT: begin
               if (c == "=") begin
                  emit(b, mk((s.mode == M_BANG) ? K_NE : (s.mode == M_EQ) ? K_EQEQ :
                             (s.mode == M_LT) ? K_LE : K_GE,
                             16'(s.start), 16'd2, s.line, '0, 1'b0, '0));
                  s.mode = M_IDLE;
               end else fl = 1'b1;
            end
            default: begin
               s.mode = M_IDLE;
               fl     = 1'b1;
            end
         endcase
         if (fl) begin
            flush(s, b);
            idle_byte(s, b, c);
         end
         s.cur = s.cur + 1'b1;
      end
      if (req.source_end) begin
         flush(s, b);
         emit(b, mk(K_END, 16'(s.cur), 16'd0, s.line, '0, 1'b0, '0));
         s       = '0;
         s.mode  = M_IDLE;
         s.line  = first_line_ff;
      end
      st_in     = s;
      push_data = b;
   end

   assign push = accept && (push_data.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= '0;
         st_ff.mode    <= M_IDLE;
         st_ff.line    <= FIRST_LINE_RESET;
         first_line_ff <= FIRST_LINE_RESET;
      end else begin
         if (accept) begin
            st_ff <= st_in;
         end else if (cfg_we && st_ff.cur == '0 && st_ff.mode == M_IDLE) begin
            st_ff.line <= cfg_data;
         end
         if (cfg_we) first_line_ff <= cfg_data;
      end
   end

endmodule

FILE: design/stk_queue.sv
// Short queue of token bundles between scanner and output serializer.
module stk_queue
   import stk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       head,
   output queue_status_type qstat
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   bundle_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ff, rd_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == CW'(QUEUE_DEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign head        = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: design/stk_back.sv
// Serializer: hands out the tokens of the head bundle one per cycle while rsp.ready is high.
module stk_back
   import stk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head,
   input  queue_status_type qstat,
   output logic             pop,
   stk_rsp_if.source        rsp
);

   logic [1:0] idx_ff;
   logic       last;
   token_type  t;

   assign t    = head.tok[idx_ff];
   assign last = ({1'b0, idx_ff} + 3'd1) == head.count;

   assign rsp.valid          = !qstat.empty;
   assign rsp.token_kind     = t.kind;
   assign rsp.token_offset   = t.offset;
   assign rsp.token_length   = t.length;
   assign rsp.token_line     = t.line;
   assign rsp.integer_value  = t.value;
   assign rsp.value_overflow = t.overflow;
   assign rsp.bad_character  = t.bad;
   assign rsp.last_of_run    = last;

   assign pop = rsp.valid && rsp.ready && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (rsp.valid && rsp.ready) begin
         idx_ff <= last ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

FILE: design/source_tokenizer_unit.sv
// Top level of the source tokenizer: scanner, bundle queue and token serializer.
// The scanner takes one source byte per cycle whenever the four-entry bundle queue
// has room, and the serializer sends one token per cycle while the receiver is ready,
// so sustained throughput is one item per cycle while items complete at most one token
// each; an item that completes several tokens (up to four) holds the output until all
// are sent. Tokens pass through the queue registers. The first line number written on
// csr_wr_data is loaded at the next source, or at once while no source byte is consumed.
module source_tokenizer_unit
   import stk_pkg::*;
#(
   parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   stk_req_if.sink     req_ch,
   stk_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic             push, pop;
   bundle_type       push_data, head;
   queue_status_type qstat;

   stk_front #(
      .OFFSET_BITS   (OFFSET_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cfg_we    (csr_wr_en),
      .cfg_data  (csr_wr_data),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   stk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   stk_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // end of source always closes the run of tokens
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.token_kind == K_END |-> rsp_ch.last_of_run)
      else $error("end token not last of run");

   // a full queue must stall the scanner
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !req_ch.ready)
      else $error("input ready while queue full");

   // a queued bundle never holds zero tokens
   a_bundle_nonempty: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty |-> head.count != 3'd0)
      else $error("empty bundle in queue");

   // popping with nothing pushed leaves room next cycle
   a_pop_frees: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> !qstat.full)
      else $error("queue still full after pop");

endmodule
